// File: hdl/obsd_pkg.sv
// Shared types and constants for the output blink sequence driver.
// Holds operation and mode codes, the item and result structs and table sizing.
// No dependencies.
`default_nettype none

package obsd_pkg;

    localparam int SEQ_DEPTH = 16;
    // Width of a table position; a depth of one still keeps one bit.
    localparam int SEQ_PW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    // Width that holds any length up to the largest allowed depth, plus one.
    localparam int LEN_W = 9;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_RESTART  = 3'd1,
        OP_OVR_SET  = 3'd2,
        OP_OVR_CLR  = 3'd3,
        OP_WRITE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_MANUAL  = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_COUNTED = 2'd2,
        MODE_SEQ     = 2'd3
    } run_mode_t;

    typedef enum logic [2:0] {
        CFG_RUN_MODE    = 3'd0,
        CFG_ON_TIME     = 3'd1,
        CFG_OFF_TICKS   = 3'd2,
        CFG_START_PHASE = 3'd3,
        CFG_PHASE_COUNT = 3'd4,
        CFG_SEQ_LENGTH  = 3'd5,
        CFG_SEQ_REPEATS = 3'd6,
        CFG_POLARITY    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  run_mode;
        logic [31:0] on_time;
        logic [31:0] off_ticks;
        logic        start_phase;
        logic [15:0] phase_count;
        logic [4:0]  seq_length;
        logic [15:0] seq_repeats;
        logic        polarity;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now;
        logic        override_level;
        logic [3:0]  entry_index;
        logic        entry_level;
        logic [31:0] entry_time;
    } item_t;

    typedef struct packed {
        logic       pin_level;
        logic [1:0] active_mode;
        logic       override_active;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/output_blink_sequence_driver_core.sv
// Top level of the output blink sequence driver.
// Instantiates obsd_cfg_regs, obsd_in_reg, obsd_engine and obsd_out_reg;
// depends on obsd_pkg.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    mode, now, override_level, entry_*
//   m_       out        m_valid/m_ready    pin_level, active_mode, override_active
//   cfg_     in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One item per clock sustained while m_ready stays high: an item waits in the input register,
// its state update is one subtract-and-compare pass, and its result is then registered in
// the output register, whose valid flag drives m_valid on the m_ channel.
// Synchronous active-low reset clears all control state; table entries are
// left undefined until written. A stalled m_ready holds the result register,
// and the input register still takes one more item before s_ready drops.
`default_nettype none

module output_blink_sequence_driver_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_mode,
    input  wire logic [31:0]  s_now,
    input  wire logic         s_override_level,
    input  wire logic [3:0]   s_entry_index,
    input  wire logic         s_entry_level,
    input  wire logic [31:0]  s_entry_time,

    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_pin_level,
    output logic [1:0]        m_active_mode,
    output logic              m_override_active,

    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    obsd_pkg::cfg_t    cfg;
    obsd_pkg::item_t   s_item;
    obsd_pkg::item_t   item;
    obsd_pkg::result_t result;
    obsd_pkg::result_t m_result;
    logic              item_valid;
    logic              can_load;
    logic              step_en;

    // Bundle the input ports into one item.
    assign s_item.mode           = s_mode;
    assign s_item.now            = s_now;
    assign s_item.override_level = s_override_level;
    assign s_item.entry_index    = s_entry_index;
    assign s_item.entry_level    = s_entry_level;
    assign s_item.entry_time     = s_entry_time;

    // Advance the held item whenever the result register has room.
    assign step_en = item_valid && can_load;

    obsd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    obsd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .step_en    (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    obsd_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (step_en),
        .item    (item),
        .result  (result)
    );

    obsd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Unpack the result onto its ports.
    assign m_pin_level       = m_result.pin_level;
    assign m_active_mode     = m_result.active_mode;
    assign m_override_active = m_result.override_active;

endmodule

`default_nettype wire

// File: hdl/obsd_cfg_regs.sv
// Configuration register file of the output blink sequence driver.
// Depends on obsd_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module obsd_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_wdata,
    output obsd_pkg::cfg_t     cfg
);

    obsd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_mode    <= obsd_pkg::MODE_MANUAL;
            cfg_reg.on_time     <= 32'd0;
            cfg_reg.off_ticks   <= 32'd0;
            cfg_reg.start_phase <= 1'b1;
            cfg_reg.phase_count <= 16'd1;
            cfg_reg.seq_length  <= 5'd1;
            cfg_reg.seq_repeats <= 16'd0;
            cfg_reg.polarity    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                obsd_pkg::CFG_RUN_MODE:    cfg_reg.run_mode    <= cfg_wdata[1:0];
                obsd_pkg::CFG_ON_TIME:     cfg_reg.on_time     <= cfg_wdata;
                obsd_pkg::CFG_OFF_TICKS:   cfg_reg.off_ticks   <= cfg_wdata;
                obsd_pkg::CFG_START_PHASE: cfg_reg.start_phase <= cfg_wdata[0];
                obsd_pkg::CFG_PHASE_COUNT: cfg_reg.phase_count <= cfg_wdata[15:0];
                obsd_pkg::CFG_SEQ_LENGTH:  cfg_reg.seq_length  <= cfg_wdata[4:0];
                obsd_pkg::CFG_SEQ_REPEATS: cfg_reg.seq_repeats <= cfg_wdata[15:0];
                obsd_pkg::CFG_POLARITY:    cfg_reg.polarity    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/obsd_in_reg.sv
// Input register of the output blink sequence driver: holds one accepted item.
// Depends on obsd_pkg for item_t.
`default_nettype none

module obsd_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire obsd_pkg::item_t s_item,
    input  wire logic          step_en,
    output logic               item_valid,
    output obsd_pkg::item_t    item
);

    logic            valid_reg;
    obsd_pkg::item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle.
    assign s_ready = !valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: hdl/obsd_engine.sv
// Timing and sequencing state of the output blink sequence driver.
// Applies one item per step to the mode state and the sequence table.
// Depends on obsd_pkg for codes, structs and table sizing.
`default_nettype none

module obsd_engine (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire obsd_pkg::cfg_t  cfg,
    input  wire logic          step_en,
    input  wire obsd_pkg::item_t item,
    output obsd_pkg::result_t  result
);

    localparam int PW = obsd_pkg::SEQ_PW;
    localparam int LW = obsd_pkg::LEN_W;

    logic          pin_reg,          pin_next;
    logic [1:0]    cur_mode_reg,     cur_mode_next;
    logic          phase_on_reg,     phase_on_next;
    logic [31:0]   phase_start_reg,  phase_start_next;
    logic [15:0]   phases_left_reg,  phases_left_next;
    logic          ovr_reg,          ovr_next;
    logic [PW-1:0] seq_pos_reg,      seq_pos_next;
    logic [15:0]   repeats_left_reg, repeats_left_next;
    logic [31:0]   step_wait_reg,    step_wait_next;
    logic [31:0]   step_start_reg,   step_start_next;

    logic          tab_level_reg [obsd_pkg::SEQ_DEPTH];
    logic [31:0]   tab_time_reg  [obsd_pkg::SEQ_DEPTH];

    logic          tab_we;
    logic [LW-1:0] wr_idx_ext;
    logic [PW-1:0] wr_idx;
    logic [LW-1:0] pos_ext;
    logic [PW-1:0] rd_idx;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] len;
    logic [LW-1:0] seq_len_ext;
    logic [31:0]   dur;
    logic [31:0]   phase_elapsed;
    logic [31:0]   step_elapsed;
    logic [15:0]   phases_dec;

    assign wr_idx_ext    = LW'(item.entry_index);
    assign wr_idx        = wr_idx_ext[PW-1:0];
    assign pos_ext       = LW'(seq_pos_reg);
    assign rd_idx        = (pos_ext < LW'(obsd_pkg::SEQ_DEPTH)) ? seq_pos_reg : '0;
    assign pos_inc       = LW'(rd_idx) + LW'(1);
    assign seq_len_ext   = LW'(cfg.seq_length);
    assign dur           = phase_on_reg ? cfg.on_time : cfg.off_ticks;
    assign phase_elapsed = item.now - phase_start_reg;
    assign step_elapsed  = item.now - step_start_reg;
    assign phases_dec    = phases_left_reg - 16'd1;

    // Clamp the used length into 1..depth.
    always_comb begin
        if (seq_len_ext == '0) begin
            len = LW'(1);
        end else if (seq_len_ext > LW'(obsd_pkg::SEQ_DEPTH)) begin
            len = LW'(obsd_pkg::SEQ_DEPTH);
        end else begin
            len = seq_len_ext;
        end
    end

    always_comb begin
        pin_next          = pin_reg;
        cur_mode_next     = cur_mode_reg;
        phase_on_next     = phase_on_reg;
        phase_start_next  = phase_start_reg;
        phases_left_next  = phases_left_reg;
        ovr_next          = ovr_reg;
        seq_pos_next      = seq_pos_reg;
        repeats_left_next = repeats_left_reg;
        step_wait_next    = step_wait_reg;
        step_start_next   = step_start_reg;
        tab_we            = 1'b0;

        if (step_en) begin
            case (item.mode)
                obsd_pkg::OP_TICK: begin
                    if (cur_mode_reg == obsd_pkg::MODE_FREE ||
                        cur_mode_reg == obsd_pkg::MODE_COUNTED) begin
                        if (dur <= phase_elapsed) begin
                            phase_on_next    = !phase_on_reg;
                            phase_start_next = item.now;
                            if (!ovr_reg) begin
                                pin_next = !phase_on_reg ^ cfg.polarity;
                            end
                            if (cur_mode_reg == obsd_pkg::MODE_COUNTED) begin
                                phases_left_next = phases_dec;
                                if (phases_dec == 16'd0) begin
                                    cur_mode_next = obsd_pkg::MODE_MANUAL;
                                end
                            end
                        end
                    end else if (cur_mode_reg == obsd_pkg::MODE_SEQ) begin
                        if (step_wait_reg <= step_elapsed) begin
                            step_start_next = item.now;
                            step_wait_next  = tab_time_reg[rd_idx];
                            if (!ovr_reg) begin
                                pin_next = tab_level_reg[rd_idx] ^ cfg.polarity;
                            end
                            if (pos_inc >= len) begin
                                seq_pos_next = '0;
                                if (repeats_left_reg != 16'd0) begin
                                    repeats_left_next = repeats_left_reg - 16'd1;
                                    if (repeats_left_reg == 16'd1) begin
                                        cur_mode_next = obsd_pkg::MODE_MANUAL;
                                    end
                                end
                            end else begin
                                seq_pos_next = pos_inc[PW-1:0];
                            end
                        end
                    end
                end
                obsd_pkg::OP_RESTART: begin
                    cur_mode_next = cfg.run_mode;
                    if (cfg.run_mode == obsd_pkg::MODE_FREE ||
                        cfg.run_mode == obsd_pkg::MODE_COUNTED) begin
                        phase_on_next    = cfg.start_phase;
                        phase_start_next = item.now;
                        phases_left_next = (cfg.run_mode == obsd_pkg::MODE_COUNTED) ?
                                           cfg.phase_count : 16'd0;
                        if (!ovr_reg) begin
                            pin_next = cfg.start_phase ^ cfg.polarity;
                        end
                    end else if (cfg.run_mode == obsd_pkg::MODE_SEQ) begin
                        seq_pos_next      = '0;
                        repeats_left_next = cfg.seq_repeats;
                        step_wait_next    = 32'd0;
                        step_start_next   = 32'd0;
                    end
                end
                obsd_pkg::OP_OVR_SET: begin
                    ovr_next = 1'b1;
                    pin_next = item.override_level ^ cfg.polarity;
                end
                obsd_pkg::OP_OVR_CLR: begin
                    ovr_next = 1'b0;
                end
                obsd_pkg::OP_WRITE: begin
                    tab_we = (wr_idx_ext < LW'(obsd_pkg::SEQ_DEPTH));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg          <= 1'b0;
            cur_mode_reg     <= obsd_pkg::MODE_MANUAL;
            phase_on_reg     <= 1'b1;
            phase_start_reg  <= 32'd0;
            phases_left_reg  <= 16'd0;
            ovr_reg          <= 1'b0;
            seq_pos_reg      <= '0;
            repeats_left_reg <= 16'd0;
            step_wait_reg    <= 32'd0;
            step_start_reg   <= 32'd0;
        end else begin
            pin_reg          <= pin_next;
            cur_mode_reg     <= cur_mode_next;
            phase_on_reg     <= phase_on_next;
            phase_start_reg  <= phase_start_next;
            phases_left_reg  <= phases_left_next;
            ovr_reg          <= ovr_next;
            seq_pos_reg      <= seq_pos_next;
            repeats_left_reg <= repeats_left_next;
            step_wait_reg    <= step_wait_next;
            step_start_reg   <= step_start_next;
        end
    end

    // Table entries hold garbage until written.
    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_level_reg[wr_idx] <= item.entry_level;
            tab_time_reg[wr_idx]  <= item.entry_time;
        end
    end

    assign result.pin_level       = pin_next;
    assign result.active_mode     = cur_mode_next;
    assign result.override_active = ovr_next;

endmodule

`default_nettype wire

// File: hdl/obsd_out_reg.sv
// Result register of the output blink sequence driver.
// Depends on obsd_pkg for result_t.
`default_nettype none

module obsd_out_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire obsd_pkg::result_t result,
    output logic               can_load,
    output logic               m_valid,
    input  wire logic          m_ready,
    output obsd_pkg::result_t  m_result
);

    logic              valid_reg;
    obsd_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for output_blink_sequence_driver_core: queues timestamped items,
// predicts pin level, running mode and override flag per item and checks each result.
// Depends on obsd_pkg and the RTL under hdl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obsd_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = '0;
    logic [31:0] s_now = '0;
    logic        s_override_level = 1'b0;
    logic [3:0]  s_entry_index = '0;
    logic        s_entry_level = 1'b0;
    logic [31:0] s_entry_time = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pin_level;
    logic [1:0]  m_active_mode;
    logic        m_override_active;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    output_blink_sequence_driver_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_now             (s_now),
        .s_override_level  (s_override_level),
        .s_entry_index     (s_entry_index),
        .s_entry_level     (s_entry_level),
        .s_entry_time      (s_entry_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pin_level       (m_pin_level),
        .m_active_mode     (m_active_mode),
        .m_override_active (m_override_active),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Items waiting for the driver, and pin results still owed by the block.
    item_t   pending_items[$];
    result_t pin_expect_q[$];
    item_t   cur_item;

    // Register copy as the block should hold it.
    cfg_t settings_now;

    // Pin driver state as the block should hold it.
    logic                 pin_now;
    run_mode_t            cur_mode;
    logic                 phase_on;
    logic [31:0]          phase_start;
    logic [15:0]          phases_left;
    logic                 ovr_held;
    logic [SEQ_PW-1:0]    seq_pos;
    logic [15:0]          reps_left;
    logic [31:0]          step_wait;
    logic [31:0]          step_start;
    logic                 tbl_level [SEQ_DEPTH];
    logic [31:0]          tbl_time  [SEQ_DEPTH];

    int   fail_count = 0;
    int   results_seen = 0;
    int   items_sent = 0;
    int   settings_applied = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   quiet_cycles = 0;
    result_t seen_res;
    result_t want_res;

    // ------------------------------------------------------------------
    // Pin prediction
    // ------------------------------------------------------------------

    // Timed pin updates are dropped while the override holds the pin.
    function automatic void drive_level(input logic lvl);
        if (!ovr_held)
            pin_now = lvl ^ settings_now.polarity;
    endfunction

    function automatic result_t pin_model_step(input item_t it);
        logic [31:0] dur;
        int unsigned len;
        int unsigned pos;
        result_t r;
        case (it.mode)
            OP_TICK: begin
                if (cur_mode == MODE_FREE || cur_mode == MODE_COUNTED) begin
                    dur = phase_on ? settings_now.on_time : settings_now.off_ticks;
                    // Modular elapsed time: a phase ends once its duration is reached.
                    if (dur <= it.now - phase_start) begin
                        phase_on = ~phase_on;
                        drive_level(phase_on);
                        phase_start = it.now;
                        if (cur_mode == MODE_COUNTED) begin
                            phases_left = phases_left - 16'd1;
                            if (phases_left == 16'd0)
                                cur_mode = MODE_MANUAL;
                        end
                    end
                end else if (cur_mode == MODE_SEQ) begin
                    if (step_wait <= it.now - step_start) begin
                        // Length 0 plays one entry, lengths past the table clamp to it.
                        if (settings_now.seq_length == 5'd0)
                            len = 1;
                        else if (settings_now.seq_length > SEQ_DEPTH)
                            len = SEQ_DEPTH;
                        else
                            len = settings_now.seq_length;
                        pos = seq_pos;
                        step_start = it.now;
                        drive_level(tbl_level[pos]);
                        step_wait = tbl_time[pos];
                        pos++;
                        if (pos >= len) begin
                            pos = 0;
                            // Zero repeats loops forever.
                            if (reps_left != 16'd0) begin
                                reps_left = reps_left - 16'd1;
                                if (reps_left == 16'd0)
                                    cur_mode = MODE_MANUAL;
                            end
                        end
                        seq_pos = pos[SEQ_PW-1:0];
                    end
                end
            end
            OP_RESTART: begin
                cur_mode = run_mode_t'(settings_now.run_mode);
                if (cur_mode == MODE_FREE || cur_mode == MODE_COUNTED) begin
                    phase_on = settings_now.start_phase;
                    phases_left = (cur_mode == MODE_COUNTED) ? settings_now.phase_count : 16'd0;
                    drive_level(phase_on);
                    phase_start = it.now;
                end else if (cur_mode == MODE_SEQ) begin
                    // Step timer cleared to zero so the first tick always plays entry 0.
                    seq_pos = '0;
                    reps_left = settings_now.seq_repeats;
                    step_wait = '0;
                    step_start = '0;
                end
            end
            OP_OVR_SET: begin
                ovr_held = 1'b1;
                pin_now = it.override_level ^ settings_now.polarity;
            end
            OP_OVR_CLR: begin
                // Pin keeps its level until the next timed update.
                ovr_held = 1'b0;
            end
            OP_WRITE: begin
                tbl_level[it.entry_index] = it.entry_level;
                tbl_time[it.entry_index] = it.entry_time;
            end
            default: begin
                // Unused codes change nothing but still return a result.
            end
        endcase
        r.pin_level = pin_now;
        r.active_mode = cur_mode;
        r.override_active = ovr_held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items, hold each until accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pin_expect_q.push_back(pin_model_step(cur_item));
                items_sent <= items_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_valid          <= 1'b1;
                    s_mode           <= cur_item.mode;
                    s_now            <= cur_item.now;
                    s_override_level <= cur_item.override_level;
                    s_entry_index    <= cur_item.entry_index;
                    s_entry_level    <= cur_item.entry_level;
                    s_entry_time     <= cur_item.entry_time;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_res.pin_level = m_pin_level;
                seen_res.active_mode = m_active_mode;
                seen_res.override_active = m_override_active;
                results_seen++;
                if (pin_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: pin %b mode %0d override %b",
                                 seen_res.pin_level, seen_res.active_mode,
                                 seen_res.override_active);
                end else begin
                    want_res = pin_expect_q.pop_front();
                    if (seen_res.pin_level !== want_res.pin_level ||
                        seen_res.active_mode !== want_res.active_mode ||
                        seen_res.override_active !== want_res.override_active) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result %0d: expected pin %b mode %0d override %b",
                                     results_seen, want_res.pin_level,
                                     want_res.active_mode, want_res.override_active);
                            $display("result %0d: got      pin %b mode %0d override %b",
                                     results_seen, seen_res.pin_level,
                                     seen_res.active_mode, seen_res.override_active);
                        end
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold the result side off once for a long stretch so the block fills and
    // drops s_ready while the driver keeps offering.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= 150) begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end
    end

    // Watchdog on handshake activity.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results owed",
                         STALL_LIMIT, pin_expect_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [2:0] op, input logic [31:0] stamp,
                             input logic ovr_lvl, input logic [3:0] idx,
                             input logic lvl, input logic [31:0] ticks);
        item_t it;
        it.mode = op;
        it.now = stamp;
        it.override_level = ovr_lvl;
        it.entry_index = idx;
        it.entry_level = lvl;
        it.entry_time = ticks;
        pending_items.push_back(it);
    endtask

    // Write one register; bits above its width carry junk the block must drop.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] word;
        case (idx)
            CFG_RUN_MODE:    mask = 32'h0000_0003;
            CFG_ON_TIME:     mask = 32'hFFFF_FFFF;
            CFG_OFF_TICKS:   mask = 32'hFFFF_FFFF;
            CFG_START_PHASE: mask = 32'h0000_0001;
            CFG_PHASE_COUNT: mask = 32'h0000_FFFF;
            CFG_SEQ_LENGTH:  mask = 32'h0000_001F;
            CFG_SEQ_REPEATS: mask = 32'h0000_FFFF;
            default:         mask = 32'h0000_0001;
        endcase
        word = ($urandom & ~mask) | (val & mask);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        case (idx)
            CFG_RUN_MODE:    settings_now.run_mode = word[1:0];
            CFG_ON_TIME:     settings_now.on_time = word;
            CFG_OFF_TICKS:   settings_now.off_ticks = word;
            CFG_START_PHASE: settings_now.start_phase = word[0];
            CFG_PHASE_COUNT: settings_now.phase_count = word[15:0];
            CFG_SEQ_LENGTH:  settings_now.seq_length = word[4:0];
            CFG_SEQ_REPEATS: settings_now.seq_repeats = word[15:0];
            default:         settings_now.polarity = word[0];
        endcase
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_RUN_MODE, 32'(c.run_mode));
        write_reg(CFG_ON_TIME, c.on_time);
        write_reg(CFG_OFF_TICKS, c.off_ticks);
        write_reg(CFG_START_PHASE, 32'(c.start_phase));
        write_reg(CFG_PHASE_COUNT, 32'(c.phase_count));
        write_reg(CFG_SEQ_LENGTH, 32'(c.seq_length));
        write_reg(CFG_SEQ_REPEATS, 32'(c.seq_repeats));
        write_reg(CFG_POLARITY, 32'(c.polarity));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Wait until every item is taken and every result is back.
    task automatic wait_idle;
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || pin_expect_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Durations: mostly short so phases and steps turn over, some extremes.
    function automatic logic [31:0] pick_ticks();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 32'($urandom_range(10));
        else if (roll < 80)
            return 32'd0;
        else if (roll < 88)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Settings for one random phase; the phase number steers the mode and extremes.
    function automatic cfg_t pick_settings(input int phase);
        cfg_t c;
        case (phase)
            0, 4:    c.run_mode = MODE_SEQ;
            1, 3:    c.run_mode = MODE_COUNTED;
            2:       c.run_mode = MODE_FREE;
            default: c.run_mode = 2'($urandom_range(3));
        endcase
        c.on_time = pick_ticks();
        c.off_ticks = pick_ticks();
        c.start_phase = 1'($urandom_range(1));
        case (phase)
            3:       c.phase_count = 16'd0;
            5:       c.phase_count = 16'hFFFF;
            default: c.phase_count = 16'($urandom_range(1, 5));
        endcase
        case (phase)
            0:       c.seq_length = 5'd31;
            4:       c.seq_length = 5'd16;
            default: c.seq_length = 5'($urandom_range(20));
        endcase
        case (phase)
            0:       c.seq_repeats = 16'd0;
            4:       c.seq_repeats = 16'hFFFF;
            default: c.seq_repeats = 16'($urandom_range(3));
        endcase
        c.polarity = 1'($urandom_range(1));
        return c;
    endfunction

    // Restart, then mostly advancing ticks with overrides, table writes and noise.
    task automatic queue_random_phase(input int phase);
        logic [31:0] stamp;
        logic [2:0]  op;
        int          roll;
        stamp = (phase == 0) ? 32'hFFFF_FFE0 : $urandom;
        // Fill the whole table before any playback can reach past the first entries.
        if (phase == 0)
            for (int i = 0; i < SEQ_DEPTH; i++)
                push_item(OP_WRITE, $urandom, 1'($urandom), 4'(i), 1'($urandom), pick_ticks());
        push_item(OP_RESTART, stamp, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                if ($urandom_range(49) == 0)
                    stamp = $urandom;
                else
                    stamp = stamp + 32'($urandom_range(5));
                op = OP_TICK;
            end else if (roll < 77) begin
                op = OP_RESTART;
            end else if (roll < 83) begin
                op = OP_OVR_SET;
            end else if (roll < 89) begin
                op = OP_OVR_CLR;
            end else if (roll < 96) begin
                op = OP_WRITE;
            end else begin
                op = 3'($urandom_range(5, 7));
            end
            push_item(op, stamp, 1'($urandom), 4'($urandom), 1'($urandom), pick_ticks());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_t c;

        settings_now = '{run_mode: MODE_MANUAL, on_time: 32'd0, off_ticks: 32'd0,
                         start_phase: 1'b1, phase_count: 16'd1, seq_length: 5'd1,
                         seq_repeats: 16'd0, polarity: 1'b0};
        pin_now = 1'b0;
        cur_mode = MODE_MANUAL;
        phase_on = 1'b1;
        phase_start = '0;
        phases_left = '0;
        ovr_held = 1'b0;
        seq_pos = '0;
        reps_left = '0;
        step_wait = '0;
        step_start = '0;
        for (int i = 0; i < SEQ_DEPTH; i++) begin
            tbl_level[i] = 1'b0;
            tbl_time[i] = '0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 60;

        // Free blink with inverted polarity, override over timing, table writes.
        c = '{run_mode: MODE_FREE, on_time: 32'd2, off_ticks: 32'd3, start_phase: 1'b1,
              phase_count: 16'd0, seq_length: 5'd0, seq_repeats: 16'd2, polarity: 1'b1};
        apply_settings(c);
        push_item(OP_TICK, 32'd0, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_RESTART, 32'd100, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd101, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd102, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_OVR_SET, 32'd103, 1'b1, 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd105, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_OVR_CLR, 32'd106, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'hFFFF_FFFF, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_WRITE, $urandom, 1'($urandom), 4'd0, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_WRITE, $urandom, 1'($urandom), 4'd1, 1'b0, 32'd0);
        push_item(OP_WRITE, $urandom, 1'($urandom), 4'd15, 1'b1, 32'd5);
        push_item(3'd5, $urandom, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(3'd7, $urandom, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        wait_idle();

        // Two-entry sequence played once: longest wait, then a wrapped elapsed time.
        c = '{run_mode: MODE_SEQ, on_time: 32'd0, off_ticks: 32'hFFFF_FFFF, start_phase: 1'b0,
              phase_count: 16'd3, seq_length: 5'd2, seq_repeats: 16'd1, polarity: 1'b0};
        apply_settings(c);
        push_item(OP_RESTART, 32'd50, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd7, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd6, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        wait_idle();

        // Counted blink through zero and full-range durations until it stops.
        c.run_mode = MODE_COUNTED;
        apply_settings(c);
        push_item(OP_RESTART, 32'd0, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd1, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'hFFFF_FFFF, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd5, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd4, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        push_item(OP_TICK, 32'd9, 1'($urandom), 4'($urandom), 1'($urandom), $urandom);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Sender idles lightly first, then the receiver, then neither.
            if (phase < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 60;
            end else if (phase < 4) begin
                send_idle_pct = 60;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_settings(pick_settings(phase));
            queue_random_phase(phase);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (pin_expect_q.size() != 0) begin
            $display("%0d expected results never arrived", pin_expect_q.size());
            fail_count += pin_expect_q.size();
        end
        $display("covered %0d items under %0d register settings, all four run modes",
                 items_sent, settings_applied);
        $display("compared %0d results, %0d errors", results_seen, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
